[rtl/trb_pkg.sv]
package trb_pkg;

    localparam int NUM_TOPICS      = 8;
    localparam int SLOTS_PER_TOPIC = 16;
    localparam int TOPIC_W         = 3;
    localparam int SLOT_W          = $clog2(SLOTS_PER_TOPIC);
    localparam int ADDR_W          = TOPIC_W + SLOT_W;
    localparam int TOTAL_SLOTS     = NUM_TOPICS * SLOTS_PER_TOPIC;
    localparam int TAG_W           = 32;
    localparam int SEQ_W           = 31;
    localparam int TIME_W          = 48;
    localparam int PUB_W           = 3;
    localparam int PAY_W           = 32;
    localparam int NIB_W           = 4;

    localparam logic [TAG_W-1:0] SENTINEL_TAG = '1;
    localparam logic [SEQ_W-1:0] SEQ_MAX      = '1;

    typedef enum logic [1:0] {
        REQ_ENQ  = 2'd0,
        REQ_GET  = 2'd1,
        REQ_DEQ  = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_FULL          = 3'd1,
        ST_NO_TOPIC      = 3'd2,
        ST_EMPTY         = 3'd3,
        ST_TOO_YOUNG     = 3'd4,
        ST_NOTHING_NEWER = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_CAPS   = 2'd1,
        REG_DELTA  = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ENQ_CHK,
        S_GET_SCAN,
        S_GET_PICK,
        S_GET_FILL,
        S_DEQ_CHK,
        S_DEQ_WR,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        req_t              req;
        logic [TOPIC_W-1:0] topic;
        logic [SEQ_W-1:0]  seen_seq;
        logic [PUB_W-1:0]  pub_id;
        logic [PAY_W-1:0]  payload;
        logic [TIME_W-1:0] now_us;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [SEQ_W-1:0]  ret_value;
        logic [SEQ_W-1:0]  entry_seq;
        logic [TIME_W-1:0] entry_time;
        logic [PUB_W-1:0]  entry_pub_id;
        logic [PAY_W-1:0]  entry_payload;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [PUB_W-1:0]  publisher;
        logic [PAY_W-1:0]  handle;
    } slot_data_t;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [TAG_W-1:0]  wdata;
    } tag_req_t;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        slot_data_t        wdata;
    } data_req_t;

    function automatic logic [SLOT_W-1:0] topic_len(input logic [31:0] caps,
                                                    input logic [TOPIC_W-1:0] t);
        logic [NIB_W-1:0] nib;
        nib = caps[{t, 2'b00} +: NIB_W];
        if (32'(nib) > 32'(SLOTS_PER_TOPIC - 1))
            return SLOT_W'(SLOTS_PER_TOPIC - 1);
        else
            return SLOT_W'(nib);
    endfunction

endpackage

[rtl/trb_slot_store.sv]
module trb_slot_store (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         caps,
    input  logic                cap_wr,
    input  trb_pkg::tag_req_t   tag_req,
    output logic [31:0]         tag_rd,
    input  trb_pkg::data_req_t  data_req,
    output trb_pkg::slot_data_t data_rd
);
    import trb_pkg::*;

    logic [TAG_W-1:0]  tag_ram [TOTAL_SLOTS];
    slot_data_t        data_ram [TOTAL_SLOTS];
    logic [TOTAL_SLOTS-1:0] valid_reg;
    logic [TAG_W-1:0]  tag_q_reg;
    logic              valid_q_reg;
    logic              dflt_sent_reg;
    slot_data_t        data_q_reg;
    logic [SLOT_W-1:0] rd_len;

    assign rd_len = topic_len(caps, tag_req.addr[ADDR_W-1:SLOT_W]);

    // unwritten slots read back as the ring's initial contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cap_wr)
        begin
            valid_reg <= '0;
        end
        else if (tag_req.wr)
        begin
            valid_reg[tag_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_req.wr)
            tag_ram[tag_req.addr] <= tag_req.wdata;
        if (tag_req.rd)
        begin
            tag_q_reg     <= tag_ram[tag_req.addr];
            valid_q_reg   <= valid_reg[tag_req.addr];
            dflt_sent_reg <= (tag_req.addr[SLOT_W-1:0] == rd_len);
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_req.wr)
            data_ram[data_req.addr] <= data_req.wdata;
        if (data_req.rd)
            data_q_reg <= data_ram[data_req.addr];
    end

    assign tag_rd  = valid_q_reg ? tag_q_reg : (dflt_sent_reg ? SENTINEL_TAG : '0);
    assign data_rd = data_q_reg;

endmodule

[rtl/trb_ctrl.sv]
module trb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  trb_pkg::item_t      in_item,
    input  logic                cap_wr,
    input  logic [7:0]          enable,
    input  logic [31:0]         caps,
    input  logic [31:0]         delta,
    output trb_pkg::tag_req_t   tag_req,
    input  logic [31:0]         tag_rd,
    output trb_pkg::data_req_t  data_req,
    input  trb_pkg::slot_data_t data_rd,
    output logic                res_valid,
    input  logic                res_ready,
    output trb_pkg::result_t    res
);
    import trb_pkg::*;

    ctrl_state_t       state_reg, state_next;
    item_t             item_reg, item_next;
    result_t           res_reg, res_next;
    logic [SLOT_W-1:0] head_reg [NUM_TOPICS];
    logic [SLOT_W-1:0] head_next [NUM_TOPICS];
    logic [SLOT_W-1:0] tail_reg [NUM_TOPICS];
    logic [SLOT_W-1:0] tail_next [NUM_TOPICS];
    logic [SEQ_W-1:0]  next_tag_reg, next_tag_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              exact_hit_reg, exact_hit_next;
    logic [SLOT_W-1:0] exact_idx_reg, exact_idx_next;
    logic              gt_hit_reg, gt_hit_next;
    logic [SLOT_W-1:0] gt_idx_reg, gt_idx_next;
    logic [SEQ_W-1:0]  gt_tag_reg, gt_tag_next;

    logic [TOPIC_W-1:0] t;
    logic [SLOT_W-1:0]  len;
    logic [SLOT_W-1:0]  head;
    logic [SLOT_W-1:0]  tail;
    logic               exists;
    logic [TAG_W-1:0]   target;
    logic               is_sent;
    logic               hit_eq;
    logic               hit_gt;
    logic               too_young;

    assign t       = item_reg.topic;
    assign len     = topic_len(caps, t);
    assign head    = head_reg[t];
    assign tail    = tail_reg[t];
    assign exists  = enable[t];
    assign target  = {1'b0, item_reg.seen_seq} + TAG_W'(1);
    assign is_sent = (tag_rd == SENTINEL_TAG);
    assign hit_eq  = !is_sent && (tag_rd == target);
    assign hit_gt  = !is_sent && (tag_rd > target);
    assign too_young = (item_reg.now_us < data_rd.stamp) ||
                       ((item_reg.now_us - data_rd.stamp) < {16'b0, delta});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            next_tag_reg <= SEQ_W'(1);
            for (int i = 0; i < NUM_TOPICS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            next_tag_reg <= next_tag_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        res_reg       <= res_next;
        idx_reg       <= idx_next;
        exact_hit_reg <= exact_hit_next;
        exact_idx_reg <= exact_idx_next;
        gt_hit_reg    <= gt_hit_next;
        gt_idx_reg    <= gt_idx_next;
        gt_tag_reg    <= gt_tag_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        next_tag_next  = next_tag_reg;
        idx_next       = idx_reg;
        exact_hit_next = exact_hit_reg;
        exact_idx_next = exact_idx_reg;
        gt_hit_next    = gt_hit_reg;
        gt_idx_next    = gt_idx_reg;
        gt_tag_next    = gt_tag_reg;
        tag_req        = '0;
        data_req       = '0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_item;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_next       = '0;
                exact_hit_next = 1'b0;
                gt_hit_next    = 1'b0;
                if (item_reg.req == REQ_NONE)
                begin
                    state_next = S_DONE;
                end
                else if (!exists)
                begin
                    res_next.status = ST_NO_TOPIC;
                    state_next      = S_DONE;
                end
                else if (item_reg.req == REQ_ENQ)
                begin
                    tag_req.rd   = 1'b1;
                    tag_req.addr = {t, tail};
                    state_next   = S_ENQ_CHK;
                end
                else if (head == tail)
                begin
                    res_next.status = ST_EMPTY;
                    state_next      = S_DONE;
                end
                else if (item_reg.req == REQ_GET)
                begin
                    tag_req.rd   = 1'b1;
                    tag_req.addr = {t, {SLOT_W{1'b0}}};
                    idx_next     = '0;
                    state_next   = S_GET_SCAN;
                end
                else
                begin
                    data_req.rd   = 1'b1;
                    data_req.addr = {t, head};
                    state_next    = S_DEQ_CHK;
                end
            end
            S_ENQ_CHK:
            begin
                if (is_sent)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    tag_req.wr     = 1'b1;
                    tag_req.addr   = {t, tail};
                    tag_req.wdata  = {1'b0, next_tag_reg};
                    data_req.wr    = 1'b1;
                    data_req.addr  = {t, tail};
                    data_req.wdata = '{stamp: item_reg.now_us, publisher: item_reg.pub_id,
                                       handle: item_reg.payload};
                    next_tag_next  = (next_tag_reg == SEQ_MAX) ? SEQ_W'(1)
                                                               : SEQ_W'(next_tag_reg + 1'b1);
                    tail_next[t]   = (tail == len) ? '0 : SLOT_W'(tail + 1'b1);
                    res_next.ret_value = SEQ_W'(1);
                end
                state_next = S_DONE;
            end
            S_GET_SCAN:
            begin
                if (hit_eq && !exact_hit_reg)
                begin
                    exact_hit_next = 1'b1;
                    exact_idx_next = idx_reg;
                end
                if (hit_gt && !gt_hit_reg)
                begin
                    gt_hit_next = 1'b1;
                    gt_idx_next = idx_reg;
                    gt_tag_next = tag_rd[SEQ_W-1:0];
                end
                if (idx_reg == len)
                begin
                    state_next = S_GET_PICK;
                end
                else
                begin
                    tag_req.rd   = 1'b1;
                    tag_req.addr = {t, SLOT_W'(idx_reg + 1'b1)};
                    idx_next     = SLOT_W'(idx_reg + 1'b1);
                end
            end
            S_GET_PICK:
            begin
                if (exact_hit_reg)
                begin
                    data_req.rd        = 1'b1;
                    data_req.addr      = {t, exact_idx_reg};
                    res_next.ret_value = SEQ_W'(1);
                    res_next.entry_seq = target[SEQ_W-1:0];
                    state_next         = S_GET_FILL;
                end
                else if (gt_hit_reg)
                begin
                    data_req.rd        = 1'b1;
                    data_req.addr      = {t, gt_idx_reg};
                    res_next.ret_value = gt_tag_reg;
                    res_next.entry_seq = gt_tag_reg;
                    state_next         = S_GET_FILL;
                end
                else
                begin
                    res_next.status = ST_NOTHING_NEWER;
                    state_next      = S_DONE;
                end
            end
            S_GET_FILL:
            begin
                res_next.entry_time    = data_rd.stamp;
                res_next.entry_pub_id  = data_rd.publisher;
                res_next.entry_payload = data_rd.handle;
                state_next             = S_DONE;
            end
            S_DEQ_CHK:
            begin
                if (too_young)
                begin
                    res_next.status = ST_TOO_YOUNG;
                    state_next      = S_DONE;
                end
                else
                begin
                    // old sentinel slot becomes free
                    tag_req.wr    = 1'b1;
                    tag_req.addr  = {t, (head == '0) ? len : SLOT_W'(head - 1'b1)};
                    tag_req.wdata = '0;
                    state_next    = S_DEQ_WR;
                end
            end
            S_DEQ_WR:
            begin
                tag_req.wr         = 1'b1;
                tag_req.addr       = {t, head};
                tag_req.wdata      = SENTINEL_TAG;
                head_next[t]       = (head == len) ? '0 : SLOT_W'(head + 1'b1);
                res_next.ret_value = SEQ_W'(1);
                state_next         = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cap_wr)
        begin
            for (int i = 0; i < NUM_TOPICS; i++)
            begin
                head_next[i] = '0;
                tail_next[i] = '0;
            end
        end
    end

    assign res = res_reg;

endmodule

[rtl/timestamped_topic_ring_buffer.sv]
// Timestamped topic ring buffer: eight topic queues of up to fifteen entries.
// Requests enter on the s_axis channel, one result per request leaves on
// m_axis. Registers (enable, capacities, delta_us) are set over APB at byte
// addresses 0, 4, 8; write them only while no request is in flight.
// A capacities write re-initializes every ring at once (per-slot valid bits).
// One request is processed at a time. A get scans the single-port tag
// memory with one read per slot of the ring, then makes one slot-data read
// when an entry is found. The next transfer is accepted in the cycle after
// the result moves into the output register.
// The result sits in an output register; s_tready is high only while the
// controller is idle, and a stalled m_tready holds the result and the block.
// Reset clears the rings to empty, head/tail to zero and the tag counter to 1.
module timestamped_topic_ring_buffer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // topic[2:0], seen_seq[33:3], pub_id[36:34], payload[68:37], now_us[116:69]
    input  logic [119:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], ret_value[33:3], entry_seq[64:34], entry_time[112:65],
    // entry_pub_id[115:113], entry_payload[147:116]
    output logic [151:0] m_tdata
);
    import trb_pkg::*;

    logic [7:0]   enable_reg;
    logic [31:0]  caps_reg;
    logic [31:0]  delta_reg;
    logic         wr;
    logic         cap_wr;
    reg_idx_t     reg_idx;
    item_t        in_item;
    tag_req_t     tag_req;
    logic [31:0]  tag_rd;
    data_req_t    data_req;
    slot_data_t   data_rd;
    logic         res_valid;
    logic         res_ready;
    result_t      res;
    logic         m_tvalid_reg;
    logic [151:0] m_tdata_reg;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr      = psel && penable && pwrite;
    assign cap_wr  = wr && (reg_idx == REG_CAPS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            caps_reg   <= '0;
            delta_reg  <= 32'd2000000;
        end
        else if (wr)
        begin
            unique case (reg_idx)
                REG_ENABLE: enable_reg <= pwdata[7:0];
                REG_CAPS:   caps_reg   <= pwdata;
                REG_DELTA:  delta_reg  <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ENABLE: prdata = {24'b0, enable_reg};
            REG_CAPS:   prdata = caps_reg;
            REG_DELTA:  prdata = delta_reg;
            default:    prdata = '0;
        endcase
    end

    assign in_item = '{req: req_t'(s_tuser), topic: s_tdata[2:0],
                       seen_seq: s_tdata[33:3], pub_id: s_tdata[36:34],
                       payload: s_tdata[68:37], now_us: s_tdata[116:69]};

    trb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .cap_wr    (cap_wr),
        .enable    (enable_reg),
        .caps      (caps_reg),
        .delta     (delta_reg),
        .tag_req   (tag_req),
        .tag_rd    (tag_rd),
        .data_req  (data_req),
        .data_rd   (data_rd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    trb_slot_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .caps     (caps_reg),
        .cap_wr   (cap_wr),
        .tag_req  (tag_req),
        .tag_rd   (tag_rd),
        .data_req (data_req),
        .data_rd  (data_rd)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_ready)
            m_tvalid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            m_tdata_reg <= {4'b0, res.entry_payload, res.entry_pub_id, res.entry_time,
                            res.entry_seq, res.ret_value, res.status};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
